@@ rtl/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants of the rational arithmetic and reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } rar_cmd_e;

  localparam int unsigned RES_NUM_W = 32;
  localparam int unsigned RES_DEN_W = 31;
  localparam int unsigned REM_W     = 30;

  typedef struct packed {
    logic num_neg;
    logic den_neg;
    logic err;
  } rar_flags_t;

  typedef struct packed {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic [RES_NUM_W-1:0] whole;
    logic [REM_W-1:0]     rem;
    logic                 mixed;
    logic                 status;
  } rar_result_t;

endpackage

`default_nettype wire

@@ rtl/rational_arith_reduce_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit
// Signed fraction add, subtract, multiply and divide with gcd reduction.
// ----------------------------------------------------------------------------
// The unit accepts one word per clock cycle while in_stall_o is low and
// returns each result in order. Behind three stages of magnitude, cross
// product and signed sum lie the binary gcd pipeline of 2 * (2 * W + 1)
// steps and the two chained restoring dividers of 2 * W + 1 stages each. A
// two-word output buffer lets one finished word wait while input continues;
// the input stalls only when both entries are held.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_reduce_unit import rar_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0] b_den_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [RES_NUM_W-1:0]     result_num_o,
  output logic [RES_DEN_W-1:0]     result_den_o,
  output logic [RES_NUM_W-1:0]     whole_part_o,
  output logic [REM_W-1:0]         rem_num_o,
  output logic                     is_mixed_o,
  output logic                     status_o
);

  localparam int unsigned NW = 2 * OPERAND_WIDTH + 1;

  logic        en;
  logic        out_valid_q, skid_valid_q;
  rar_result_t out_q, skid_q, res_d;

  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  logic          fr_valid;
  logic [NW-1:0] fr_num, fr_den;
  rar_flags_t    fr_flags;

  rar_front #(.W(OPERAND_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cmd_i   (command_i),
    .a_num_i (a_num_i),
    .a_den_i (a_den_i),
    .b_num_i (b_num_i),
    .b_den_i (b_den_i),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .flags_o (fr_flags)
  );

  logic          gc_valid;
  logic [NW-1:0] gc_num, gc_den, gc_gcd;
  rar_flags_t    gc_flags;

  rar_gcd #(.NW(NW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .flags_i (fr_flags),
    .valid_o (gc_valid),
    .num_o   (gc_num),
    .den_o   (gc_den),
    .gcd_o   (gc_gcd),
    .flags_o (gc_flags)
  );

  logic          dn_valid, dd_valid;
  logic [NW-1:0] dn_quot, dn_rem, dd_quot, dd_rem;
  logic [1:0]    dn_side;
  logic          dd_side;

  rar_div #(.NW(NW), .SW(2)) u_div_num (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (gc_valid),
    .dividend_i (gc_num),
    .divisor_i  (gc_gcd),
    .side_i     ({gc_flags.num_neg, gc_flags.den_neg}),
    .valid_o    (dn_valid),
    .quot_o     (dn_quot),
    .rem_o      (dn_rem),
    .side_o     (dn_side)
  );

  rar_div #(.NW(NW), .SW(1)) u_div_den (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (gc_valid),
    .dividend_i (gc_den),
    .divisor_i  (gc_gcd),
    .side_i     (gc_flags.err),
    .valid_o    (dd_valid),
    .quot_o     (dd_quot),
    .rem_o      (dd_rem),
    .side_o     (dd_side)
  );

  logic          red_neg;
  logic          wq_valid;
  logic [NW-1:0] wq_quot, wq_rem, wq_nm, wq_dm;
  logic          wq_neg, wq_err;

  assign red_neg = (dn_quot != '0) && (dn_side[1] ^ dn_side[0]);

  rar_div #(.NW(NW), .SW(2 * NW + 2)) u_div_whole (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dn_valid),
    .dividend_i (dn_quot),
    .divisor_i  (dd_quot),
    .side_i     ({dn_quot, dd_quot, red_neg, dd_side}),
    .valid_o    (wq_valid),
    .quot_o     (wq_quot),
    .rem_o      (wq_rem),
    .side_o     ({wq_nm, wq_dm, wq_neg, wq_err})
  );

  logic [RES_NUM_W-1:0] nm_w, q_w;

  always_comb begin
    nm_w         = RES_NUM_W'(wq_nm);
    q_w          = RES_NUM_W'(wq_quot);
    res_d.num    = wq_neg ? (RES_NUM_W'(0) - nm_w) : nm_w;
    res_d.den    = RES_DEN_W'(wq_dm);
    res_d.whole  = (wq_neg && wq_quot != '0) ? (RES_NUM_W'(0) - q_w) : q_w;
    res_d.rem    = REM_W'(wq_rem);
    res_d.mixed  = (wq_nm > wq_dm) && (wq_dm != NW'(1));
    res_d.status = 1'b0;
    if (wq_err) begin
      res_d        = '0;
      res_d.status = 1'b1;
    end
  end

  logic push, pop;

  assign push = wq_valid && en;
  assign pop  = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_num_o = out_q.num;
  assign result_den_o = out_q.den;
  assign whole_part_o = out_q.whole;
  assign rem_num_o    = out_q.rem;
  assign is_mixed_o   = out_q.mixed;
  assign status_o     = out_q.status;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output word");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_valid == dd_valid)
    else $error("reduction dividers out of step");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_valid |-> dn_rem == '0 && dd_rem == '0)
    else $error("gcd does not divide the unreduced fraction");

  a_skid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q && out_valid_q)
    else $error("buffered word dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_den_o == '0 && rem_num_o == '0)
    else $error("error word carries a nonzero result");

endmodule

`default_nettype wire

@@ rtl/rar_front.sv @@
// ----------------------------------------------------------------------------
// rar_front
// Operand magnitudes, cross products and signed sum: three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_front import rar_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [1:0]        cmd_i,
  input  logic [W-1:0]      a_num_i,
  input  logic [W-1:0]      a_den_i,
  input  logic [W-1:0]      b_num_i,
  input  logic [W-1:0]      b_den_i,
  output logic              valid_o,
  output logic [2*W:0]      num_o,
  output logic [2*W:0]      den_o,
  output rar_flags_t        flags_o
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned NW = 2 * W + 1;

  logic [W-1:0] raw [4];
  logic [W-1:0] mag_d [4];
  logic         neg_d [4];

  assign raw[0] = a_num_i;
  assign raw[1] = a_den_i;
  assign raw[2] = b_num_i;
  assign raw[3] = b_den_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_d[i] = raw[i][W-1];
      mag_d[i] = raw[i][W-1] ? (~raw[i]) + W'(1) : raw[i];
    end
  end

  logic         s1_valid_q;
  rar_cmd_e     s1_cmd_q;
  logic [W-1:0] s1_mag_q [4];
  logic         s1_neg_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q <= rar_cmd_e'(cmd_i);
      for (int i = 0; i < 4; i++) begin
        s1_mag_q[i] <= mag_d[i];
        s1_neg_q[i] <= neg_d[i];
      end
    end
  end

  logic          s2_valid_q;
  rar_cmd_e      s2_cmd_q;
  logic [PW-1:0] s2_an_bd_q, s2_ad_bn_q, s2_ad_bd_q, s2_an_bn_q;
  logic          s2_sg_an_bd_q, s2_sg_ad_bn_q, s2_sg_ad_bd_q, s2_sg_an_bn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_cmd_q      <= s1_cmd_q;
      s2_an_bd_q    <= PW'(s1_mag_q[0]) * PW'(s1_mag_q[3]);
      s2_ad_bn_q    <= PW'(s1_mag_q[1]) * PW'(s1_mag_q[2]);
      s2_ad_bd_q    <= PW'(s1_mag_q[1]) * PW'(s1_mag_q[3]);
      s2_an_bn_q    <= PW'(s1_mag_q[0]) * PW'(s1_mag_q[2]);
      s2_sg_an_bd_q <= s1_neg_q[0] ^ s1_neg_q[3];
      s2_sg_ad_bn_q <= s1_neg_q[1] ^ s1_neg_q[2];
      s2_sg_ad_bd_q <= s1_neg_q[1] ^ s1_neg_q[3];
      s2_sg_an_bn_q <= s1_neg_q[0] ^ s1_neg_q[2];
    end
  end

  logic [PW-1:0] x_mag, y_mag, d_mag;
  logic          x_neg, y_neg, d_neg;
  logic [NW-1:0] sum_d;
  logic          sum_neg_d;

  always_comb begin
    x_mag = s2_an_bd_q;
    x_neg = s2_sg_an_bd_q;
    y_mag = '0;
    y_neg = 1'b0;
    d_mag = s2_ad_bd_q;
    d_neg = s2_sg_ad_bd_q;
    case (s2_cmd_q)
      CMD_ADD: begin
        y_mag = s2_ad_bn_q;
        y_neg = s2_sg_ad_bn_q;
      end
      CMD_SUB: begin
        y_mag = s2_ad_bn_q;
        y_neg = ~s2_sg_ad_bn_q;
      end
      CMD_MUL: begin
        x_mag = s2_an_bn_q;
        x_neg = s2_sg_an_bn_q;
      end
      CMD_DIV: begin
        d_mag = s2_ad_bn_q;
        d_neg = s2_sg_ad_bn_q;
      end
      default: begin
        y_mag = '0;
      end
    endcase
    x_neg = x_neg && (x_mag != '0);
    y_neg = y_neg && (y_mag != '0);
    d_neg = d_neg && (d_mag != '0);
    if (x_neg == y_neg) begin
      sum_d     = NW'(x_mag) + NW'(y_mag);
      sum_neg_d = x_neg;
    end else if (x_mag >= y_mag) begin
      sum_d     = NW'(x_mag - y_mag);
      sum_neg_d = x_neg;
    end else begin
      sum_d     = NW'(y_mag - x_mag);
      sum_neg_d = y_neg;
    end
    if (sum_d == '0) begin
      sum_neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o           <= sum_d;
      den_o           <= NW'(d_mag);
      flags_o.num_neg <= sum_neg_d;
      flags_o.den_neg <= d_neg;
      flags_o.err     <= (d_mag == '0);
    end
  end

endmodule

`default_nettype wire

@@ rtl/rar_gcd.sv @@
// ----------------------------------------------------------------------------
// rar_gcd
// Pipelined binary greatest common divisor, one reduction step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_gcd import rar_pkg::*; #(
  parameter int unsigned NW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  rar_flags_t    flags_i,
  output logic          valid_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] den_o,
  output logic [NW-1:0] gcd_o,
  output rar_flags_t    flags_o
);

  localparam int unsigned STEPS = 2 * NW;
  localparam int unsigned KW    = $clog2(NW + 1);

  logic          valid_q [STEPS];
  logic [NW-1:0] u_q     [STEPS];
  logic [NW-1:0] v_q     [STEPS];
  logic [KW-1:0] k_q     [STEPS];
  logic [NW-1:0] num_q   [STEPS];
  logic [NW-1:0] den_q   [STEPS];
  rar_flags_t    flags_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic          valid_in;
    logic [NW-1:0] u_in, v_in, num_in, den_in, u_d, v_d;
    logic [KW-1:0] k_in, k_d;
    rar_flags_t    flags_in;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign u_in     = num_i;
      assign v_in     = den_i;
      assign k_in     = '0;
      assign num_in   = num_i;
      assign den_in   = den_i;
      assign flags_in = flags_i;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign u_in     = u_q[i-1];
      assign v_in     = v_q[i-1];
      assign k_in     = k_q[i-1];
      assign num_in   = num_q[i-1];
      assign den_in   = den_q[i-1];
      assign flags_in = flags_q[i-1];
    end

    always_comb begin
      u_d = u_in;
      v_d = v_in;
      k_d = k_in;
      if (u_in == '0 || v_in == '0) begin
        u_d = u_in;
      end else if (!u_in[0] && !v_in[0]) begin
        u_d = u_in >> 1;
        v_d = v_in >> 1;
        k_d = k_in + KW'(1);
      end else if (!u_in[0]) begin
        u_d = u_in >> 1;
      end else if (!v_in[0]) begin
        v_d = v_in >> 1;
      end else if (u_in >= v_in) begin
        u_d = (u_in - v_in) >> 1;
      end else begin
        v_d = (v_in - u_in) >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q[i]     <= u_d;
        v_q[i]     <= v_d;
        k_q[i]     <= k_d;
        num_q[i]   <= num_in;
        den_q[i]   <= den_in;
        flags_q[i] <= flags_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gcd_o   <= (u_q[STEPS-1] | v_q[STEPS-1]) << k_q[STEPS-1];
      num_o   <= num_q[STEPS-1];
      den_o   <= den_q[STEPS-1];
      flags_o <= flags_q[STEPS-1];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rar_div.sv @@
// ----------------------------------------------------------------------------
// rar_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_div #(
  parameter int unsigned NW = 33,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [NW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [NW];
  logic [NW-1:0] r_q     [NW];
  logic [NW-1:0] nq_q    [NW];
  logic [NW-1:0] d_q     [NW];
  logic [SW-1:0] side_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          valid_in;
    logic [NW-1:0] r_in, nq_in, d_in, r_d, nq_d;
    logic [SW-1:0] side_in;
    logic [NW:0]   trial;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign r_in     = '0;
      assign nq_in    = dividend_i;
      assign d_in     = divisor_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign r_in     = r_q[i-1];
      assign nq_in    = nq_q[i-1];
      assign d_in     = d_q[i-1];
      assign side_in  = side_q[i-1];
    end

    always_comb begin
      trial = {r_in, nq_in[NW-1]};
      if (trial >= {1'b0, d_in}) begin
        r_d  = NW'(trial - {1'b0, d_in});
        nq_d = {nq_in[NW-2:0], 1'b1};
      end else begin
        r_d  = trial[NW-1:0];
        nq_d = {nq_in[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]    <= r_d;
        nq_q[i]   <= nq_d;
        d_q[i]    <= d_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NW-1];
  assign quot_o  = nq_q[NW-1];
  assign rem_o   = r_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

`default_nettype wire
